/* hw/rtl/lmx_pkg.sv */
// Package for the Lamport mutex node: sizes, codes, queue entry type and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmx_pkg;

  localparam int NODES       = 16;
  localparam int QUEUE_DEPTH = 32;

  localparam int TS_W     = 31;
  localparam int NODE_W   = 4;
  localparam int NC_W     = 5;
  localparam int CMP_W    = 8;
  localparam int NIDX_W   = $clog2(NODES);
  localparam int QIDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W  = TS_W + NODE_W;

  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NODE_COUNT = 1'd1;

  localparam logic [2:0] FN_RECV_REQ  = 3'd0;
  localparam logic [2:0] FN_RECV_ACK  = 3'd1;
  localparam logic [2:0] FN_RECV_REL  = 3'd2;
  localparam logic [2:0] FN_LOCAL_LCK = 3'd3;
  localparam logic [2:0] FN_LOCAL_REL = 3'd4;

  localparam logic [1:0] KIND_REQ = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_REL = 2'd2;

  typedef struct packed {
    logic [TS_W-1:0]   stamp;
    logic [NODE_W-1:0] node;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic ins_rd;
    logic ins_cmp;
    logic ins_put;
    logic rem_rd;
    logic rem_cmp;
    logic grant_rd;
    logic grant_head;
    logic scan;
    logic load;
  } lmx_cmd_t;

  typedef struct packed {
    logic ins_go;
    logic rem_go;
    logic queue_empty;
    logic ins_place;
    logic ins_to_zero;
    logic rem_last;
    logic head_mine;
    logic no_peers;
    logic scan_end;
    logic out_free;
  } lmx_status_t;

  function automatic logic [TS_W-1:0] bump(input logic [TS_W-1:0] v);
    return (v == TS_MAX) ? TS_MAX : v + TS_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lmx_if.sv */
// Channel interfaces for the Lamport mutex node: request items in, results out.
// Depends on lmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lmx_req_if import lmx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [TS_W-1:0]   msg_timestamp;
  logic [NODE_W-1:0] msg_node;

  modport source (output valid, func, msg_timestamp, msg_node, input ready);
  modport sink   (input valid, func, msg_timestamp, msg_node, output ready);
endinterface

interface lmx_rsp_if import lmx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              send_valid;
  logic [1:0]        send_kind;
  logic              send_broadcast;
  logic [NODE_W-1:0] send_target;
  logic [TS_W-1:0]   send_timestamp;
  logic              granted;
  logic [TS_W-1:0]   clock_now;
  logic              queue_overflow;

  modport source (output valid, send_valid, send_kind, send_broadcast, send_target,
                  send_timestamp, granted, clock_now, queue_overflow, input ready);
  modport sink   (input valid, send_valid, send_kind, send_broadcast, send_target,
                  send_timestamp, granted, clock_now, queue_overflow, output ready);
endinterface

`default_nettype wire

/* hw/rtl/lmx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/lmx_ctrl.sv */
// Controller FSM for the Lamport mutex node: sequences clock update, queue
// walk, grant scan and result load. Depends on lmx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmx_ctrl import lmx_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         req_valid,
  output logic        req_ready,
  input  lmx_status_t st,
  output lmx_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_IRD   = 4'd3;
  localparam logic [3:0] S_ICMP  = 4'd4;
  localparam logic [3:0] S_IPUT  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RCMP  = 4'd7;
  localparam logic [3:0] S_GRD   = 4'd8;
  localparam logic [3:0] S_GHEAD = 4'd9;
  localparam logic [3:0] S_GSCAN = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DISP;
      end
      S_DISP: begin
        if (st.ins_go) begin
          state_next = st.queue_empty ? S_IPUT : S_IRD;
        end else if (st.rem_go) begin
          state_next = st.queue_empty ? S_GRD : S_RRD;
        end else begin
          state_next = S_GRD;
        end
      end
      S_IRD: begin
        cmd.ins_rd = 1'b1;
        state_next = S_ICMP;
      end
      S_ICMP: begin
        cmd.ins_cmp = 1'b1;
        if (st.ins_place)        state_next = S_GRD;
        else if (st.ins_to_zero) state_next = S_IPUT;
        else                     state_next = S_IRD;
      end
      S_IPUT: begin
        cmd.ins_put = 1'b1;
        state_next  = S_GRD;
      end
      S_RRD: begin
        cmd.rem_rd = 1'b1;
        state_next = S_RCMP;
      end
      S_RCMP: begin
        cmd.rem_cmp = 1'b1;
        state_next  = st.rem_last ? S_GRD : S_RRD;
      end
      S_GRD: begin
        cmd.grant_rd = 1'b1;
        state_next   = S_GHEAD;
      end
      S_GHEAD: begin
        cmd.grant_head = 1'b1;
        state_next     = (!st.head_mine || st.no_peers) ? S_DONE : S_GSCAN;
      end
      S_GSCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/lmx_dp.sv */
// Datapath for the Lamport mutex node: logical clock, ack table, sorted
// queue in RAM, walk index, config registers and output register.
// Depends on lmx_pkg and lmx_ram.
`timescale 1ns / 1ps
`default_nettype none

module lmx_dp import lmx_pkg::*; (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_we,
  input  wire [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire [2:0]              in_func,
  input  wire [TS_W-1:0]         in_ts,
  input  wire [NODE_W-1:0]       in_node,
  input  lmx_cmd_t               cmd,
  output lmx_status_t            st,
  input  wire                    rsp_ready,
  output logic                   rsp_valid,
  output logic                   o_send_valid,
  output logic [1:0]             o_send_kind,
  output logic                   o_send_broadcast,
  output logic [NODE_W-1:0]      o_send_target,
  output logic [TS_W-1:0]        o_send_timestamp,
  output logic                   o_granted,
  output logic [TS_W-1:0]        o_clock_now,
  output logic                   o_queue_overflow
);

  // config
  logic [NODE_W-1:0] own_id;
  logic [NC_W-1:0]   node_count;

  // state
  logic [TS_W-1:0]   lclock;
  logic [CNT_W-1:0]  count;
  logic [TS_W-1:0]   ack [NODES];

  // current item
  logic [2:0]        it_func;
  logic [TS_W-1:0]   it_ts;
  logic [NODE_W-1:0] it_node;

  // walk
  logic              ins_go, rem_go, found;
  entry_t            key;
  logic [QIDX_W-1:0] j;
  logic [CMP_W-1:0]  si;
  logic [TS_W-1:0]   mine;

  // pending result
  logic              r_sv, r_bc, r_gr, r_ovf;
  logic [1:0]        r_kind;
  logic [NODE_W-1:0] r_tgt;
  logic [TS_W-1:0]   r_sts;

  // RAM
  logic              ram_we;
  logic [QIDX_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;

  lmx_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  logic [TS_W-1:0]  mx, b1, b2, lb;
  logic             full, greater, match, last, fail;
  logic [CMP_W-1:0] n_eff, own_ext, node_ext, nc_ext;
  logic [CNT_W-1:0] cnt_m1;

  always_comb begin
    mx       = (it_ts > lclock) ? it_ts : lclock;
    b1       = bump(mx);
    b2       = bump(b1);
    lb       = bump(lclock);
    full     = (count >= CNT_W'(QUEUE_DEPTH));
    cnt_m1   = count - CNT_W'(1);
    own_ext  = CMP_W'(own_id);
    node_ext = CMP_W'(it_node);
    nc_ext   = CMP_W'(node_count);
    n_eff    = (nc_ext > CMP_W'(NODES)) ? CMP_W'(NODES) : nc_ext;
    greater  = (rd.stamp > key.stamp) || ((rd.stamp == key.stamp) && (rd.node > key.node));
    match    = !found && (rd.node == key.node);
    last     = (CNT_W'(j) == cnt_m1);
    fail     = (si != own_ext) && (ack[si[NIDX_W-1:0]] < mine);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j + QIDX_W'(1);
    ram_wdata = rd;
    ram_raddr = '0;
    if (cmd.ins_cmp) begin
      ram_we    = 1'b1;
      ram_wdata = greater ? rd : key;
    end else if (cmd.ins_put) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = key;
    end else if (cmd.rem_cmp) begin
      ram_we    = found;
      ram_waddr = j - QIDX_W'(1);
    end else if (cmd.ins_rd || cmd.rem_rd) begin
      ram_raddr = j;
    end else if (cmd.grant_rd) begin
      ram_raddr = '0;
    end
  end

  always_comb begin
    st.ins_go      = ins_go;
    st.rem_go      = rem_go;
    st.queue_empty = (count == '0);
    st.ins_place   = !greater;
    st.ins_to_zero = greater && (j == '0);
    st.rem_last    = last;
    st.head_mine   = (count != '0) && (rd.node == own_id);
    st.no_peers    = (n_eff == '0);
    st.scan_end    = fail || (si == n_eff - CMP_W'(1));
    st.out_free    = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id     <= '0;
      node_count <= NC_W'(2);
      lclock     <= '0;
      count      <= '0;
      ins_go     <= 1'b0;
      rem_go     <= 1'b0;
      rsp_valid  <= 1'b0;
      for (int k = 0; k < NODES; k++) ack[k] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_OWN_ID)     own_id     <= cfg_wdata[NODE_W-1:0];
        if (cfg_addr == CFG_NODE_COUNT) node_count <= cfg_wdata[NC_W-1:0];
      end

      if (cmd.latch) begin
        it_func <= in_func;
        it_ts   <= in_ts;
        it_node <= in_node;
      end

      if (cmd.exec) begin
        ins_go <= 1'b0;
        rem_go <= 1'b0;
        found  <= 1'b0;
        r_sv   <= 1'b0;
        r_kind <= KIND_REQ;
        r_bc   <= 1'b0;
        r_tgt  <= '0;
        r_sts  <= '0;
        r_ovf  <= 1'b0;
        case (it_func)
          FN_RECV_REQ: begin
            lclock <= b2;
            key    <= '{stamp: it_ts, node: it_node};
            j      <= cnt_m1[QIDX_W-1:0];
            ins_go <= !full;
            r_ovf  <= full;
            if (it_node != own_id) begin
              r_sv   <= 1'b1;
              r_kind <= KIND_ACK;
              r_tgt  <= it_node;
              r_sts  <= b2;
            end
          end
          FN_RECV_ACK: begin
            lclock <= b1;
            if (node_ext < CMP_W'(NODES)) ack[node_ext[NIDX_W-1:0]] <= it_ts;
          end
          FN_RECV_REL: begin
            lclock <= b1;
            key    <= '{stamp: it_ts, node: it_node};
            j      <= '0;
            rem_go <= 1'b1;
          end
          FN_LOCAL_LCK: begin
            lclock <= lb;
            key    <= '{stamp: lb, node: own_id};
            j      <= cnt_m1[QIDX_W-1:0];
            ins_go <= !full;
            r_ovf  <= full;
            if (!full) begin
              r_sv   <= 1'b1;
              r_kind <= KIND_REQ;
              r_bc   <= 1'b1;
              r_sts  <= lb;
            end
          end
          FN_LOCAL_REL: begin
            lclock <= lb;
            key    <= '{stamp: lb, node: own_id};
            j      <= '0;
            rem_go <= 1'b1;
            r_sv   <= 1'b1;
            r_kind <= KIND_REL;
            r_bc   <= 1'b1;
            r_sts  <= lb;
          end
          default: ;
        endcase
      end

      if (cmd.ins_cmp) begin
        if (!greater)          count <= count + CNT_W'(1);
        else if (j != '0)      j     <= j - QIDX_W'(1);
      end

      if (cmd.ins_put) count <= count + CNT_W'(1);

      if (cmd.rem_cmp) begin
        if (match) found <= 1'b1;
        if (last) begin
          if (found || match) count <= cnt_m1;
        end else begin
          j <= j + QIDX_W'(1);
        end
      end

      if (cmd.grant_head) begin
        r_gr <= st.head_mine;
        mine <= rd.stamp;
        si   <= '0;
      end

      if (cmd.scan) begin
        if (fail) r_gr <= 1'b0;
        si <= si + CMP_W'(1);
      end

      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (cmd.load) begin
        rsp_valid        <= 1'b1;
        o_send_valid     <= r_sv;
        o_send_kind      <= r_kind;
        o_send_broadcast <= r_bc;
        o_send_target    <= r_tgt;
        o_send_timestamp <= r_sts;
        o_granted        <= r_gr;
        o_clock_now      <= lclock;
        o_queue_overflow <= r_ovf;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/lamport_mutex_node.sv */
// Top level of one node of Lamport's distributed lock.
// Depends on lmx_pkg, lmx_if, lmx_ctrl, lmx_dp, lmx_ram.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------
//  req     | in  | valid/ready       | func, msg_timestamp, msg_node
//  rsp     | out | valid/ready       | send_*, granted, clock_now, overflow
//  cfg     | in  | cfg_we (no ready) | cfg_addr 0 own_id, 1 node_count
//
// One item at a time. After the req transfer an item goes through setup (exec,
// dispatch), a read and a compare state per queue entry walked (sorted insert
// walks from the tail until the slot is found, release walks the whole queue;
// one RAM read port), a put state when an insert lands at the head or in an
// empty queue, the head read, then the ack scan, one peer per step (skipped
// unless our request heads the queue, cut short at the first stale ack), the
// result register load and the idle state, where the next req transfer is taken.
// Reset (rst, synchronous) clears clock, queue fill count and ack table; the
// queue RAM needs no clearing since only entries below the fill count are read.
// The result register holds while rsp stalls; a new req transfer is taken as
// soon as the previous item's result is loaded, even if it is not yet taken.
`timescale 1ns / 1ps
`default_nettype none

module lamport_mutex_node import lmx_pkg::*; (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [CFG_ADDR_W-1:0] cfg_addr,
  input  wire [CFG_DATA_W-1:0] cfg_wdata,
  lmx_req_if.sink              req,
  lmx_rsp_if.source            rsp
);

  lmx_cmd_t    cmd;
  lmx_status_t st;

  // sequencing
  lmx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // state, queue RAM and result register
  lmx_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_func          (req.func),
    .in_ts            (req.msg_timestamp),
    .in_node          (req.msg_node),
    .cmd              (cmd),
    .st               (st),
    .rsp_ready        (rsp.ready),
    .rsp_valid        (rsp.valid),
    .o_send_valid     (rsp.send_valid),
    .o_send_kind      (rsp.send_kind),
    .o_send_broadcast (rsp.send_broadcast),
    .o_send_target    (rsp.send_target),
    .o_send_timestamp (rsp.send_timestamp),
    .o_granted        (rsp.granted),
    .o_clock_now      (rsp.clock_now),
    .o_queue_overflow (rsp.queue_overflow)
  );

endmodule

`default_nettype wire

/* verif/lamport_mutex_node_tb.sv */
// Self-checking testbench for lamport_mutex_node: directed table, then random
// phases over several own_id/node_count settings. Depends on lmx_pkg, lmx_if.
`timescale 1ns / 1ps

module lamport_mutex_node_tb;
  import lmx_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 120;   // > one worst-case item (full queue walk + scan)

  typedef struct packed {
    logic              send_valid;
    logic [1:0]        send_kind;
    logic              send_broadcast;
    logic [NODE_W-1:0] send_target;
    logic [TS_W-1:0]   send_timestamp;
    logic              granted;
    logic [TS_W-1:0]   clock_now;
    logic              queue_overflow;
  } lock_result_t;

  typedef struct {
    logic [2:0]        func;
    logic [TS_W-1:0]   ts;
    logic [NODE_W-1:0] node;
    bit                typed;     // expected result written in by hand
    lock_result_t      res;
  } lock_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_OWN_ID;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  lmx_req_if req_ch ();
  lmx_rsp_if rsp_ch ();

  lamport_mutex_node dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Node model: clock, sorted request queue, ack table, config
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0] m_own;
  logic [NC_W-1:0]   m_count;
  logic [TS_W-1:0]   m_clock;
  logic [TS_W-1:0]   q_stamp [QUEUE_DEPTH];
  logic [NODE_W-1:0] q_node  [QUEUE_DEPTH];
  int                q_fill;
  logic [TS_W-1:0]   last_ack [NODES];

  lock_result_t pending_results[$];
  int  fail_count = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  valid_hi = 1'b0;   // tracks what we last drove on req valid

  function automatic logic [TS_W-1:0] sat_inc(input logic [TS_W-1:0] v);
    return (v == TS_MAX) ? TS_MAX : v + 1'b1;
  endfunction

  // sorted insert by (stamp, node); returns 0 when full
  function automatic bit queue_insert(input logic [TS_W-1:0] ts, input logic [NODE_W-1:0] nd);
    int pos;
    pos = q_fill;
    if (q_fill >= QUEUE_DEPTH) return 1'b0;
    for (int i = 0; i < q_fill; i++) begin
      if (q_stamp[i] > ts || (q_stamp[i] == ts && q_node[i] > nd)) begin
        pos = i;
        break;
      end
    end
    for (int i = q_fill; i > pos; i--) begin
      q_stamp[i] = q_stamp[i-1];
      q_node[i]  = q_node[i-1];
    end
    q_stamp[pos] = ts;
    q_node[pos]  = nd;
    q_fill++;
    return 1'b1;
  endfunction

  // free first entry of node, shift the rest down
  function automatic void queue_remove(input logic [NODE_W-1:0] nd);
    for (int i = 0; i < q_fill; i++) begin
      if (q_node[i] == nd) begin
        for (int j = i; j + 1 < q_fill; j++) begin
          q_stamp[j] = q_stamp[j+1];
          q_node[j]  = q_node[j+1];
        end
        q_fill--;
        return;
      end
    end
  endfunction

  function automatic logic lock_held();
    int peers;
    if (q_fill == 0 || q_node[0] != m_own) return 1'b0;
    peers = (m_count > NODES) ? NODES : m_count;
    for (int i = 0; i < peers; i++)
      if (i != m_own && last_ack[i] < q_stamp[0]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void merge_stamp(input logic [TS_W-1:0] ts);
    m_clock = sat_inc((ts > m_clock) ? ts : m_clock);
  endfunction

  task automatic lamport_step(input logic [2:0] f, input logic [TS_W-1:0] ts,
                              input logic [NODE_W-1:0] nd, output lock_result_t r);
    r = '0;
    case (f)
      FN_RECV_REQ: begin
        merge_stamp(ts);
        if (!queue_insert(ts, nd)) r.queue_overflow = 1'b1;
        m_clock = sat_inc(m_clock);
        // a request from ourselves gets no ack
        if (nd != m_own) begin
          r.send_valid     = 1'b1;
          r.send_kind      = KIND_ACK;
          r.send_target    = nd;
          r.send_timestamp = m_clock;
        end
      end
      FN_RECV_ACK: begin
        merge_stamp(ts);
        last_ack[nd] = ts;
      end
      FN_RECV_REL: begin
        merge_stamp(ts);
        queue_remove(nd);
      end
      FN_LOCAL_LCK: begin
        m_clock = sat_inc(m_clock);
        if (queue_insert(m_clock, m_own)) begin
          r.send_valid     = 1'b1;
          r.send_kind      = KIND_REQ;
          r.send_broadcast = 1'b1;
          r.send_timestamp = m_clock;
        end else begin
          r.queue_overflow = 1'b1;
        end
      end
      FN_LOCAL_REL: begin
        m_clock = sat_inc(m_clock);
        queue_remove(m_own);
        r.send_valid     = 1'b1;
        r.send_kind      = KIND_REL;
        r.send_broadcast = 1'b1;
        r.send_timestamp = m_clock;
      end
      default: ;  // unknown func: nothing changes
    endcase
    r.granted   = lock_held();
    r.clock_now = m_clock;
  endtask

  // ---------------------------------------------------------------------------
  // Request side: one transfer per call, bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] f, input logic [TS_W-1:0] ts,
                           input logic [NODE_W-1:0] nd, input bit typed,
                           input lock_result_t typed_res);
    lock_result_t r;
    req_ch.valid         <= 1'b1;
    req_ch.func          <= f;
    req_ch.msg_timestamp <= ts;
    req_ch.msg_node      <= nd;
    valid_hi = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    lamport_step(f, ts, nd, r);
    pending_results.push_back(typed ? typed_res : r);
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      valid_hi = 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end else begin
      burst_left--;
    end
  endtask

  // drop valid and let every expected transfer come back
  task automatic drain();
    if (valid_hi) begin
      req_ch.valid <= 1'b0;
      valid_hi = 1'b0;
      @(posedge clk);
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [NODE_W-1:0] own, input logic [NC_W-1:0] cnt);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_OWN_ID;
    cfg_wdata <= CFG_DATA_W'(own);
    @(posedge clk);
    cfg_addr  <= CFG_NODE_COUNT;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_own   = own;
    m_count = cnt;
  endtask

  // timestamp just below TS_MAX when near_top is set, else mostly near the node clock, sometimes zero or fully random
  function automatic logic [TS_W-1:0] pick_stamp(input bit near_top);
    longint t;
    int sel;
    sel = $urandom_range(0, 99);
    if (near_top) return TS_MAX - TS_W'($urandom_range(0, 6));
    if (sel < 5) return '0;
    if (sel < 12) return TS_W'($urandom);
    t = longint'(m_clock) + $urandom_range(0, 7) - 3;
    if (t < 0) t = 0;
    if (t > longint'(TS_MAX)) t = TS_MAX;
    return TS_W'(t);
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    int peers;
    peers = (m_count == 0) ? 1 : ((m_count > NODES) ? NODES : m_count);
    if ($urandom_range(0, 4) == 0) return NODE_W'($urandom);
    return NODE_W'($urandom_range(0, peers - 1));
  endfunction

  // weights: recv req, recv ack, recv rel, local lock, local rel; unknown funcs get a fixed weight of 3
  task automatic random_phase(input int n, input int w_req, input int w_ack, input int w_rel,
                              input int w_lck, input int w_lrl, input bit near_top);
    lock_result_t none;
    logic [2:0] f;
    logic [NODE_W-1:0] nd;
    int pick, total;
    none = '0;
    total = w_req + w_ack + w_rel + w_lck + w_lrl + 3;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, total - 1);
      if (pick < w_req) f = FN_RECV_REQ;
      else if (pick < w_req + w_ack) f = FN_RECV_ACK;
      else if (pick < w_req + w_ack + w_rel) f = FN_RECV_REL;
      else if (pick < w_req + w_ack + w_rel + w_lck) f = FN_LOCAL_LCK;
      else if (pick < w_req + w_ack + w_rel + w_lck + w_lrl) f = FN_LOCAL_REL;
      else f = 3'($urandom_range(5, 7));
      nd = pick_node();
      // releases mostly name a node that is actually queued
      if (f == FN_RECV_REL && q_fill > 0 && $urandom_range(0, 3) != 0)
        nd = q_node[$urandom_range(0, q_fill - 1)];
      send_item(f, pick_stamp(near_top), nd, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows start right after reset (own 0, two nodes).
  // ---------------------------------------------------------------------------
  lock_row_t dir_rows[] = '{
    // unknown func before anything happened
    '{3'd5, 31'd0, 4'd0, 1'b1, '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd0, 1'b0}},
    '{FN_RECV_ACK, 31'd0, 4'd1, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd1, 1'b0}},
    // lock: ack from node 1 still older than our stamp
    '{FN_LOCAL_LCK, 31'd0, 4'd0, 1'b1,
      '{1'b1, KIND_REQ, 1'b1, 4'd0, 31'd2, 1'b0, 31'd2, 1'b0}},
    '{FN_RECV_ACK, 31'd5, 4'd1, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b1, 31'd6, 1'b0}},
    '{FN_RECV_REQ, 31'd3, 4'd1, 1'b1,
      '{1'b1, KIND_ACK, 1'b0, 4'd1, 31'd8, 1'b1, 31'd8, 1'b0}},
    '{FN_LOCAL_REL, 31'd0, 4'd0, 1'b1,
      '{1'b1, KIND_REL, 1'b1, 4'd0, 31'd9, 1'b0, 31'd9, 1'b0}},
    '{FN_RECV_REL, 31'd0, 4'd1, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd10, 1'b0}},
    // request carrying our own id: queued, no ack
    '{FN_RECV_REQ, 31'd0, 4'd0, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b1, 31'd12, 1'b0}},
    // release from a node with no entry
    '{FN_RECV_REL, 31'd0, 4'd9, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b1, 31'd13, 1'b0}},
    // ack from a node outside node_count does not matter for grant
    '{FN_RECV_ACK, 31'd0, 4'd15, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b1, 31'd14, 1'b0}},
    '{FN_RECV_REL, 31'd0, 4'd0, 1'b1,
      '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd15, 1'b0}},
    '{3'd6, 31'd0, 4'd0, 1'b1, '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd15, 1'b0}},
    '{3'd7, TS_MAX, 4'd15, 1'b1, '{1'b0, 2'd0, 1'b0, 4'd0, 31'd0, 1'b0, 31'd15, 1'b0}},
    // from here on the model decides: ties on stamp, duplicates, stale stamps
    '{FN_RECV_REQ, 31'd20, 4'd3, 1'b0, '0},
    '{FN_RECV_REQ, 31'd20, 4'd2, 1'b0, '0},
    '{FN_RECV_REQ, 31'd20, 4'd2, 1'b0, '0},
    '{FN_RECV_REQ, 31'd0, 4'd15, 1'b0, '0},
    '{FN_LOCAL_LCK, 31'd0, 4'd0, 1'b0, '0},
    '{FN_RECV_ACK, 31'd40, 4'd1, 1'b0, '0},
    '{FN_RECV_REL, 31'd1, 4'd2, 1'b0, '0},
    '{FN_RECV_REL, 31'd1, 4'd15, 1'b0, '0},
    '{FN_RECV_REL, 31'd1, 4'd2, 1'b0, '0},
    '{FN_RECV_REL, 31'd1, 4'd3, 1'b0, '0},
    '{FN_LOCAL_REL, 31'd0, 4'd0, 1'b0, '0},
    '{FN_LOCAL_REL, 31'd0, 4'd0, 1'b0, '0}
  };

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.func          = FN_RECV_REQ;
    req_ch.msg_timestamp = '0;
    req_ch.msg_node      = '0;
    rsp_ch.ready         = 1'b0;
    m_own   = '0;
    m_count = NC_W'(2);
    m_clock = '0;
    q_fill  = 0;
    for (int i = 0; i < NODES; i++) last_ack[i] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].func, dir_rows[i].ts, dir_rows[i].node,
                dir_rows[i].typed, dir_rows[i].res);

    // settings sweep; flood phase fills the queue past QUEUE_DEPTH
    random_phase(200, 25, 30, 20, 10, 10, 1'b0);
    set_config(4'd15, 5'd16);
    random_phase(250, 25, 35, 20, 10, 10, 1'b0);
    set_config(4'd5, 5'd1);
    random_phase(150, 25, 25, 20, 15, 15, 1'b0);
    set_config(4'd0, 5'd0);
    random_phase(120, 25, 25, 20, 15, 15, 1'b0);
    set_config(4'd7, 5'd4);
    random_phase(120, 60, 10, 3, 15, 2, 1'b0);
    random_phase(200, 20, 25, 35, 10, 10, 1'b0);
    set_config(4'd12, 5'd31);
    random_phase(200, 25, 30, 20, 10, 10, 1'b0);
    set_config(4'd9, 5'd17);
    random_phase(200, 25, 30, 20, 10, 10, 1'b0);
    // clock saturation last: once at the top it stays there
    set_config(4'd3, 5'd4);
    random_phase(60, 25, 30, 20, 10, 10, 1'b1);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("lamport_mutex_node regression: pass");
    else $display("lamport_mutex_node regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall patterns on ready; check each transfer
  // ---------------------------------------------------------------------------
  int stall_mode = 0;

  function automatic void cmp_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, e, a);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    lock_result_t e;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("lamport_mutex_node regression: fail");
      $finish;
    end
    if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_ch.ready <= 1'b1;
      1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
      2: rsp_ch.ready <= (cycle_count % 7) < 2;
      default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
    endcase
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        cmp_field("send_valid", e.send_valid, rsp_ch.send_valid);
        cmp_field("send_kind", e.send_kind, rsp_ch.send_kind);
        cmp_field("send_broadcast", e.send_broadcast, rsp_ch.send_broadcast);
        cmp_field("send_target", e.send_target, rsp_ch.send_target);
        cmp_field("send_timestamp", e.send_timestamp, rsp_ch.send_timestamp);
        cmp_field("granted", e.granted, rsp_ch.granted);
        cmp_field("clock_now", e.clock_now, rsp_ch.clock_now);
        cmp_field("queue_overflow", e.queue_overflow, rsp_ch.queue_overflow);
      end
    end
  end

endmodule

/* sim.f */
hw/rtl/lmx_pkg.sv
hw/rtl/lmx_if.sv
hw/rtl/lmx_ram.sv
hw/rtl/lmx_ctrl.sv
hw/rtl/lmx_dp.sv
hw/rtl/lamport_mutex_node.sv
verif/lamport_mutex_node_tb.sv
